// File: design/sprbatch_pkg.sv
// Package for the sprite batcher: field widths, codes and parameter defaults.
// Used by sprite_batch_slot_and_quad_emit; depends on nothing else.
`default_nettype none

package sprbatch_pkg;

   // Default sizes, handed to the top-level parameters.
   localparam int MAX_QUADS_DEF     = 16384;
   localparam int SLOT_CAPACITY_DEF = 32;

   // Configuration register.
   localparam int                CFG_W          = 6;
   localparam logic [CFG_W-1:0]  SLOT_LIMIT_RST = 6'd16;
   localparam logic [CFG_W-1:0]  SLOT_LIMIT_MIN = 6'd2;

   // Fixed field widths.
   localparam int KIND_W   = 2;
   localparam int TEX_W    = 16;
   localparam int COORD_W  = 32;
   localparam int SLOTF_W  = 5;
   localparam int CORNER_W = 2;
   localparam int ICNT_W   = 17;
   localparam int DRAW_W   = 32;
   localparam int REQ_W    = 304;
   localparam int RSP_W    = 160;

   // Wide sum of one coordinate: 2*c3 +- c0 +- c1 + 1 fits in 34 bits signed; SUM_W keeps 35.
   localparam int SUM_W = COORD_W + 3;

   // Input kinds.
   localparam logic [KIND_W-1:0] KIND_SPRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

   // Result types.
   localparam logic RT_VERTEX = 1'b0;
   localparam logic RT_FLUSH  = 1'b1;

   // Saturated slot count on a flush record.
   localparam logic [SLOTF_W-1:0] SLOTF_MAX = 5'd31;

endpackage

`default_nettype wire

// File: design/sprite_batch_slot_and_quad_emit.sv
// Sprite batcher: a begin word opens a batch and clears the draw counter, a sprite word
// binds its texture to a sampler slot (searching the bound slots in turn, S_RD then S_CMP
// for each) and emits four transformed quad corners, an end word emits a draw record for a
// non-empty batch. One word is taken at a time. A sprite that misses in every bound slot
// binds a new one; running out of slots first flushes the batch, and a sprite that meets a
// full batch flushes and binds with no search. The single read port of the slot table sets
// the search time and one shared coordinate adder, giving one of x, y, z per cycle, sets the
// vertex time. Output stalls lengthen flushes and vertex pushes. Slot table entries need no
// clearing after reset: only slots bound in the current batch are ever searched.
// Depends on sprbatch_pkg.
`default_nettype none

module sprite_batch_slot_and_quad_emit #(
   parameter int MAX_QUADS     = sprbatch_pkg::MAX_QUADS_DEF,
   parameter int SLOT_CAPACITY = sprbatch_pkg::SLOT_CAPACITY_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // Input words.
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // tdata: texture_id[15:0], m_r0_c0, m_r0_c1, m_r0_c3, m_r1_c0, m_r1_c1, m_r1_c3,
   // m_r2_c0, m_r2_c1, m_r2_c3 (32 bits each, from bit 16 up)
   input  wire  [sprbatch_pkg::REQ_W-1:0]  req_tdata,
   // tuser: kind[1:0]
   input  wire  [sprbatch_pkg::KIND_W-1:0] req_tuser,
   // Result words.
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], tex_u[96], tex_v[97],
   // slot[102:98], corner[104:103], index_count[121:105], draw_number[153:122], zeros
   output logic [sprbatch_pkg::RSP_W-1:0]  rsp_tdata,
   // tuser: result_type[0]
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   // Configuration: slot_limit.
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [sprbatch_pkg::CFG_W-1:0]  csr_data
);

   localparam int QW     = $clog2(MAX_QUADS + 1);
   localparam int SLOT_W = $clog2(SLOT_CAPACITY);
   localparam int NS_W   = $clog2(SLOT_CAPACITY + 1);
   localparam int CW     = sprbatch_pkg::COORD_W;
   localparam int SW     = sprbatch_pkg::SUM_W;

   typedef enum logic [2:0] {
      S_IDLE, S_FLUSH, S_RD, S_CMP, S_NEW, S_CALC, S_PUSH
   } state_type;

   state_type                           state_ff;
   logic [sprbatch_pkg::CFG_W-1:0]      slot_limit_ff;
   logic [NS_W-1:0]                     next_slot_ff;
   logic [QW-1:0]                       quads_ff;
   logic [sprbatch_pkg::DRAW_W-1:0]     draw_calls_ff;
   logic                                fl_end_ff;
   logic [SLOT_W-1:0]                   scan_ff;
   logic [SLOT_W-1:0]                   found_ff;
   logic [1:0]                          corner_ff;
   logic [1:0]                          row_ff;
   logic [sprbatch_pkg::TEX_W-1:0]      tex_ff;
   logic signed [CW-1:0]                m_ff [9];
   logic signed [CW-1:0]                pos_ff [3];

   logic                                rsp_tvalid_ff;
   logic [sprbatch_pkg::RSP_W-1:0]      rsp_tdata_ff;
   logic                                rsp_tuser_ff;
   logic                                rsp_tlast_ff;

   // Slot table memory.
   logic [sprbatch_pkg::TEX_W-1:0]      slot_mem [SLOT_CAPACITY];
   logic [sprbatch_pkg::TEX_W-1:0]      mem_q_ff;
   logic                                mem_we;

   logic                                out_free;
   logic                                rsp_load;
   logic [sprbatch_pkg::CFG_W-1:0]      limit_eff;
   logic                                slots_full;
   logic [NS_W-1:0]                     scan_next;
   logic signed [CW-1:0]                op0;
   logic signed [CW-1:0]                op1;
   logic signed [CW-1:0]                op3;
   logic signed [SW-1:0]                sum_in;
   logic signed [SW-2:0]                half_in;
   logic signed [CW-1:0]                coord_in;
   logic                                pos_sx;
   logic                                pos_sy;
   logic [sprbatch_pkg::ICNT_W-1:0]     q17;
   logic [sprbatch_pkg::ICNT_W-1:0]     icnt_in;
   logic [sprbatch_pkg::DRAW_W-1:0]     draw_in;
   logic [5:0]                          ns6;
   logic [sprbatch_pkg::SLOTF_W-1:0]    fl_slot_in;
   logic [sprbatch_pkg::RSP_W-1:0]      flush_word;
   logic [sprbatch_pkg::RSP_W-1:0]      vert_word;
   logic                                tex_u_in;
   logic                                tex_v_in;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // A new result word is loaded by a non-empty flush or a vertex push.
   assign rsp_load = out_free &&
                     ((state_ff == S_FLUSH && quads_ff != '0) || state_ff == S_PUSH);

   // Effective slot limit, clamped into the legal range.
   always_comb begin
      if (slot_limit_ff < sprbatch_pkg::SLOT_LIMIT_MIN) begin
         limit_eff = sprbatch_pkg::SLOT_LIMIT_MIN;
      end else if (slot_limit_ff > sprbatch_pkg::CFG_W'(SLOT_CAPACITY)) begin
         limit_eff = sprbatch_pkg::CFG_W'(SLOT_CAPACITY);
      end else begin
         limit_eff = slot_limit_ff;
      end
   end

   assign ns6        = 6'(next_slot_ff);
   assign slots_full = (ns6 >= limit_eff);
   assign scan_next  = NS_W'(scan_ff) + NS_W'(1);

   // Shared coordinate unit: one row of the transform per cycle.
   always_comb begin
      unique case (row_ff)
         2'd0: begin
            op0 = m_ff[0];
            op1 = m_ff[1];
            op3 = m_ff[2];
         end
         2'd1: begin
            op0 = m_ff[3];
            op1 = m_ff[4];
            op3 = m_ff[5];
         end
         default: begin
            op0 = m_ff[6];
            op1 = m_ff[7];
            op3 = m_ff[8];
         end
      endcase
   end

   assign pos_sx = (corner_ff == 2'd1) || (corner_ff == 2'd2);
   assign pos_sy = (corner_ff == 2'd2) || (corner_ff == 2'd3);

   // Sum at double scale plus one, then an arithmetic halving rounds ties upward.
   always_comb begin
      sum_in = (SW'(op3) <<< 1)
             + (pos_sx ? SW'(op0) : -SW'(op0))
             + (pos_sy ? SW'(op1) : -SW'(op1))
             + SW'(1);
      half_in = sum_in[SW-1:1];
      if (half_in[SW-2:CW-1] == '0 || half_in[SW-2:CW-1] == '1) begin
         coord_in = half_in[CW-1:0];
      end else if (half_in[SW-2]) begin
         coord_in = {1'b1, {(CW-1){1'b0}}};
      end else begin
         coord_in = {1'b0, {(CW-1){1'b1}}};
      end
   end

   // Draw record fields.
   assign q17        = sprbatch_pkg::ICNT_W'(quads_ff);
   assign icnt_in    = (q17 << 2) + (q17 << 1);
   assign draw_in    = draw_calls_ff + sprbatch_pkg::DRAW_W'(1);
   assign fl_slot_in = (ns6 > 6'(sprbatch_pkg::SLOTF_MAX)) ? sprbatch_pkg::SLOTF_MAX
                                                          : ns6[sprbatch_pkg::SLOTF_W-1:0];
   assign flush_word = {6'd0, draw_in, icnt_in, 2'd0, fl_slot_in, 2'b00, 96'd0};

   assign tex_u_in  = pos_sx;
   assign tex_v_in  = pos_sy;
   assign vert_word = {6'd0, 32'd0, 17'd0, corner_ff,
                       sprbatch_pkg::SLOTF_W'(found_ff), tex_v_in, tex_u_in,
                       pos_ff[2], pos_ff[1], pos_ff[0]};

   assign mem_we = (state_ff == S_NEW) && !slots_full;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[next_slot_ff[SLOT_W-1:0]] <= tex_ff;
      end
      mem_q_ff <= slot_mem[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_limit_ff <= sprbatch_pkg::SLOT_LIMIT_RST;
         next_slot_ff  <= NS_W'(1);
         quads_ff      <= '0;
         draw_calls_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         fl_end_ff     <= 1'b0;
         scan_ff       <= SLOT_W'(1);
         found_ff      <= '0;
         corner_ff     <= '0;
         row_ff        <= '0;
      end else begin
         if (csr_valid) begin
            slot_limit_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  tex_ff    <= req_tdata[sprbatch_pkg::TEX_W-1:0];
                  for (int i = 0; i < 9; i++) begin
                     m_ff[i] <= req_tdata[sprbatch_pkg::TEX_W + CW*i +: CW];
                  end
                  scan_ff   <= SLOT_W'(1);
                  corner_ff <= '0;
                  row_ff    <= '0;
                  priority case (req_tuser)
                     sprbatch_pkg::KIND_SPRITE: begin
                        fl_end_ff <= 1'b0;
                        if (quads_ff >= QW'(MAX_QUADS)) begin
                           state_ff <= S_FLUSH;
                        end else if (next_slot_ff == NS_W'(1)) begin
                           state_ff <= S_NEW;
                        end else begin
                           state_ff <= S_RD;
                        end
                     end
                     sprbatch_pkg::KIND_BEGIN: begin
                        quads_ff      <= '0;
                        next_slot_ff  <= NS_W'(1);
                        draw_calls_ff <= '0;
                     end
                     sprbatch_pkg::KIND_END: begin
                        fl_end_ff <= 1'b1;
                        if (quads_ff != '0) begin
                           state_ff <= S_FLUSH;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_FLUSH: begin
               // An empty batch emits nothing; a sprite flush always restarts the batch.
               if (quads_ff == '0 || out_free) begin
                  if (quads_ff != '0) begin
                     rsp_tdata_ff  <= flush_word;
                     rsp_tuser_ff  <= sprbatch_pkg::RT_FLUSH;
                     rsp_tlast_ff  <= fl_end_ff;
                     draw_calls_ff <= draw_in;
                  end
                  if (fl_end_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     quads_ff     <= '0;
                     next_slot_ff <= NS_W'(1);
                     state_ff     <= S_NEW;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (mem_q_ff == tex_ff) begin
                  found_ff <= scan_ff;
                  state_ff <= S_CALC;
               end else if (scan_next >= next_slot_ff) begin
                  state_ff <= S_NEW;
               end else begin
                  scan_ff  <= scan_next[SLOT_W-1:0];
                  state_ff <= S_RD;
               end
            end
            S_NEW: begin
               if (slots_full) begin
                  state_ff <= S_FLUSH;
               end else begin
                  found_ff     <= next_slot_ff[SLOT_W-1:0];
                  next_slot_ff <= next_slot_ff + NS_W'(1);
                  state_ff     <= S_CALC;
               end
            end
            S_CALC: begin
               pos_ff[row_ff] <= coord_in;
               if (row_ff == 2'd2) begin
                  row_ff   <= '0;
                  state_ff <= S_PUSH;
               end else begin
                  row_ff <= row_ff + 2'd1;
               end
            end
            S_PUSH: begin
               if (out_free) begin
                  rsp_tdata_ff  <= vert_word;
                  rsp_tuser_ff  <= sprbatch_pkg::RT_VERTEX;
                  rsp_tlast_ff  <= (corner_ff == 2'd3);
                  if (corner_ff == 2'd3) begin
                     quads_ff <= quads_ff + QW'(1);
                     state_ff <= S_IDLE;
                  end else begin
                     corner_ff <= corner_ff + 2'd1;
                     state_ff  <= S_CALC;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // The bound-slot pointer never leaves its legal range.
   a_next_slot_range: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff >= NS_W'(1) && next_slot_ff <= NS_W'(SLOT_CAPACITY))
      else $error("next slot pointer out of range");

   // The batch never holds more quads than its capacity.
   a_quads_range: assert property (@(posedge clock) disable iff (reset)
      quads_ff <= QW'(MAX_QUADS))
      else $error("quad count beyond capacity");

   // A draw record always describes a non-empty batch.
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tuser_ff == sprbatch_pkg::RT_FLUSH |->
         rsp_tdata_ff[121:105] != '0)
      else $error("draw record for an empty batch");

   // The final vertex of a sprite is always corner three.
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tuser_ff == sprbatch_pkg::RT_VERTEX && rsp_tlast_ff |->
         rsp_tdata_ff[104:103] == 2'd3)
      else $error("sprite ended on a corner other than three");

   // A finished sprite adds exactly one quad to the batch.
   a_quad_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUSH && out_free && corner_ff == 2'd3 |=>
         quads_ff == $past(quads_ff) + QW'(1))
      else $error("quad count not advanced after a sprite");

endmodule

`default_nettype wire

// File: tb/sprite_batch_slot_and_quad_emit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sprite batcher: directed scenes and random word streams,
// checked against a predictor of slot binding, quad corners and draw records.
// Depends on sprbatch_pkg and sprite_batch_slot_and_quad_emit.

module sprite_batch_slot_and_quad_emit_test;

   // A small batch size lets the full-batch flush show up in a short run, while a batch
   // can still bind all 31 usable slots before it fills.
   localparam int BATCH_QUADS = 32;
   localparam int SLOT_CAP = sprbatch_pkg::SLOT_CAPACITY_DEF;
   localparam logic [sprbatch_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [sprbatch_pkg::KIND_W-1:0]          kind;
      logic [sprbatch_pkg::TEX_W-1:0]           tex;
      logic [8:0][sprbatch_pkg::COORD_W-1:0]    mat;   // row * 3 + column; c0, c1, c3
   } sprite_word_type;

   typedef struct packed {
      logic                                rtype;
      logic [sprbatch_pkg::COORD_W-1:0]    pos_x, pos_y, pos_z;
      logic                                tex_u, tex_v;
      logic [sprbatch_pkg::SLOTF_W-1:0]    slot;
      logic [sprbatch_pkg::CORNER_W-1:0]   corner;
      logic [sprbatch_pkg::ICNT_W-1:0]     index_count;
      logic [sprbatch_pkg::DRAW_W-1:0]     draw_number;
      logic                                last;
   } batch_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [sprbatch_pkg::REQ_W-1:0] req_tdata = '0;    // texture_id, then m_r0_c0 .. m_r2_c3
   logic [sprbatch_pkg::KIND_W-1:0] req_tuser = '0;   // kind
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [sprbatch_pkg::RSP_W-1:0] rsp_tdata;   // pos_x, pos_y, pos_z, tex_u, tex_v, slot,
                                                // corner, index_count, draw_number
   logic rsp_tuser;                             // result_type
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sprbatch_pkg::CFG_W-1:0] csr_data = '0;

   // Predictor state.
   logic [sprbatch_pkg::TEX_W-1:0] tex_of_slot [SLOT_CAP];
   int free_slot = 1;
   int quad_total = 0;
   logic [sprbatch_pkg::DRAW_W-1:0] draw_total = '0;
   logic [sprbatch_pkg::CFG_W-1:0] sampler_limit = sprbatch_pkg::SLOT_LIMIT_RST;
   batch_record_type owed_records [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int mismatches = 0;
   int cycle_count = 0;
   batch_record_type want, got;

   sprite_batch_slot_and_quad_emit #(
      .MAX_QUADS(BATCH_QUADS),
      .SLOT_CAPACITY(SLOT_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sprite_batch_slot_and_quad_emit] ERROR");
         $finish;
      end
   end

   // The receiver stalls at random, or holds off entirely while hold_cycles runs down.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // One coordinate: 2*c3 +- c0 +- c1 at double scale, rounded half up, then saturated.
   function automatic logic [sprbatch_pkg::COORD_W-1:0] corner_coord(
         logic [sprbatch_pkg::COORD_W-1:0] c0, c1, c3, bit px, bit py);
      longint a, b, s;
      a = longint'($signed(c0));
      b = longint'($signed(c1));
      s = 2 * longint'($signed(c3)) + (px ? a : -a) + (py ? b : -b) + 1;
      s = s >>> 1;
      if (s > COORD_MAX) s = COORD_MAX;
      if (s < COORD_MIN) s = COORD_MIN;
      return s[sprbatch_pkg::COORD_W-1:0];
   endfunction

   task automatic fresh_batch();
      free_slot = 1;
      quad_total = 0;
   endtask

   task automatic close_batch(input logic last);
      batch_record_type r;
      if (quad_total == 0) return;
      draw_total = draw_total + 1'b1;
      r = '0;
      r.rtype = sprbatch_pkg::RT_FLUSH;
      r.slot = (free_slot > 31) ? sprbatch_pkg::SLOTF_MAX
                                : free_slot[sprbatch_pkg::SLOTF_W-1:0];
      r.index_count = sprbatch_pkg::ICNT_W'(quad_total * 6);
      r.draw_number = draw_total;
      r.last = last;
      owed_records.push_back(r);
   endtask

   task automatic batch_word(input sprite_word_type w);
      int found, lim;
      batch_record_type r;
      bit px, py;
      unique case (w.kind)
         sprbatch_pkg::KIND_BEGIN: begin
            fresh_batch();
            draw_total = '0;
         end
         sprbatch_pkg::KIND_END: close_batch(1'b1);
         sprbatch_pkg::KIND_SPRITE: begin
            if (quad_total >= BATCH_QUADS) begin
               close_batch(1'b0);
               fresh_batch();
            end
            found = 0;
            for (int i = 1; i < free_slot && i < SLOT_CAP; i++)
               if (found == 0 && tex_of_slot[i] == w.tex) found = i;
            if (found == 0) begin
               lim = (sampler_limit < sprbatch_pkg::SLOT_LIMIT_MIN) ?
                        sprbatch_pkg::SLOT_LIMIT_MIN :
                     (sampler_limit > SLOT_CAP) ? SLOT_CAP : sampler_limit;
               if (free_slot >= lim) begin
                  close_batch(1'b0);
                  fresh_batch();
               end
               found = free_slot;
               tex_of_slot[found] = w.tex;
               free_slot++;
            end
            for (int k = 0; k < 4; k++) begin
               // Corners run counterclockwise from (-0.5, -0.5); u and v follow the signs.
               px = (k == 1 || k == 2);
               py = (k >= 2);
               r = '0;
               r.rtype = sprbatch_pkg::RT_VERTEX;
               r.pos_x = corner_coord(w.mat[0], w.mat[1], w.mat[2], px, py);
               r.pos_y = corner_coord(w.mat[3], w.mat[4], w.mat[5], px, py);
               r.pos_z = corner_coord(w.mat[6], w.mat[7], w.mat[8], px, py);
               r.tex_u = px;
               r.tex_v = py;
               r.slot = found[sprbatch_pkg::SLOTF_W-1:0];
               r.corner = k[sprbatch_pkg::CORNER_W-1:0];
               r.last = (k == 3);
               owed_records.push_back(r);
            end
            quad_total++;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name,
                              input logic [sprbatch_pkg::DRAW_W-1:0] want_v,
                              input logic [sprbatch_pkg::DRAW_W-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %h, got %h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.rtype = rsp_tuser;
         got.pos_x = rsp_tdata[31:0];
         got.pos_y = rsp_tdata[63:32];
         got.pos_z = rsp_tdata[95:64];
         got.tex_u = rsp_tdata[96];
         got.tex_v = rsp_tdata[97];
         got.slot = rsp_tdata[102:98];
         got.corner = rsp_tdata[104:103];
         got.index_count = rsp_tdata[121:105];
         got.draw_number = rsp_tdata[153:122];
         got.last = rsp_tlast;
         if (owed_records.size() == 0) begin
            $error("result word with nothing owed: type %b data %h", rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = owed_records.pop_front();
            check_field("result_type", want.rtype, got.rtype);
            check_field("pos_x", want.pos_x, got.pos_x);
            check_field("pos_y", want.pos_y, got.pos_y);
            check_field("pos_z", want.pos_z, got.pos_z);
            check_field("tex_u", want.tex_u, got.tex_u);
            check_field("tex_v", want.tex_v, got.tex_v);
            check_field("slot", want.slot, got.slot);
            check_field("corner", want.corner, got.corner);
            check_field("index_count", want.index_count, got.index_count);
            check_field("draw_number", want.draw_number, got.draw_number);
            check_field("last", want.last, got.last);
         end
      end
   end

   // Valid stays high from one word to the next unless the sender idles.
   task automatic send_word(input sprite_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {w.mat, w.tex};
      req_tuser <= w.kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      batch_word(w);
   endtask

   // Begin and ignored words leave no result behind, so wait out the block's latency too.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (owed_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_limit(input logic [sprbatch_pkg::CFG_W-1:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sampler_limit = v;
      csr_valid <= 1'b0;
   endtask

   function automatic sprite_word_type uniform_word(
         logic [sprbatch_pkg::KIND_W-1:0] kind, logic [sprbatch_pkg::TEX_W-1:0] tex,
         logic [sprbatch_pkg::COORD_W-1:0] c0, c1, c3);
      sprite_word_type w;
      w.kind = kind;
      w.tex = tex;
      for (int r = 0; r < 3; r++) begin
         w.mat[3*r] = c0;
         w.mat[3*r+1] = c1;
         w.mat[3*r+2] = c3;
      end
      return w;
   endfunction

   // Mostly modest transforms, some fully random, some built from the extremes.
   function automatic sprite_word_type random_word(logic [sprbatch_pkg::KIND_W-1:0] kind,
                                                   logic [sprbatch_pkg::TEX_W-1:0] tex);
      sprite_word_type w;
      int style;
      w.kind = kind;
      w.tex = tex;
      style = $urandom_range(9);
      for (int i = 0; i < 9; i++) begin
         if (style < 6) begin
            w.mat[i] = sprbatch_pkg::COORD_W'(int'($urandom_range(2097152)) - 1048576);
         end else if (style < 8) begin
            w.mat[i] = $urandom();
         end else begin
            case ($urandom_range(5))
               0: w.mat[i] = 32'h7FFF_FFFF;
               1: w.mat[i] = 32'h8000_0000;
               2: w.mat[i] = 32'h0000_0000;
               3: w.mat[i] = 32'h0000_0001;
               4: w.mat[i] = 32'hFFFF_FFFF;
               default: w.mat[i] = 32'h7FFF_FFFE;
            endcase
         end
      end
      return w;
   endfunction

   task automatic test_scene_basics();
      send_idle_pct = 0;
      stall_pct = 0;
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h1234));   // nothing batched: no draw
      send_word(random_word(KIND_NONE, 16'hFFFF));
      send_word(random_word(sprbatch_pkg::KIND_BEGIN, 16'h0000));
      send_word(uniform_word(sprbatch_pkg::KIND_SPRITE, 16'h0000, '0, '0, '0));
      send_word(uniform_word(sprbatch_pkg::KIND_SPRITE, 16'hFFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_word(uniform_word(sprbatch_pkg::KIND_SPRITE, 16'h0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000));
      // Odd double-scale sums land exactly halfway between codes and round up.
      send_word(uniform_word(sprbatch_pkg::KIND_SPRITE, 16'h0001, 32'h0000_0001,
                             32'h0000_0002, 32'hFFFF_FFFF));
      send_word(uniform_word(sprbatch_pkg::KIND_SPRITE, 16'hFFFF, 32'h0001_0000,
                             32'h0001_0000, 32'h0005_0000));
      send_word(uniform_word(sprbatch_pkg::KIND_SPRITE, 16'h5A5A, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h0000));
      // The batch survives an end word and is drawn again.
      send_word(random_word(sprbatch_pkg::KIND_END, 16'hA5A5));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0001));
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h0001));
      send_word(random_word(sprbatch_pkg::KIND_BEGIN, 16'hFFFF));
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h0000));
      send_word(random_word(KIND_NONE, 16'h0000));
   endtask

   task automatic test_slot_limit_clamp();
      send_idle_pct = 0;
      stall_pct = 0;
      // Limits below two act as two: one usable slot per batch.
      write_slot_limit(6'd0);
      send_word(random_word(sprbatch_pkg::KIND_BEGIN, 16'h0100));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0100));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0100));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0101));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0100));
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h0100));
      write_slot_limit(6'd1);
      send_word(random_word(sprbatch_pkg::KIND_BEGIN, 16'h0102));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0102));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0103));
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h0103));
      write_slot_limit(6'd63);
      send_word(random_word(sprbatch_pkg::KIND_BEGIN, 16'h0200));
      for (int i = 0; i < 6; i++)
         send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0200 + 16'(i)));
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h0200));
   endtask

   task automatic test_full_batches();
      send_idle_pct = 15;
      stall_pct = 15;
      write_slot_limit(6'd32);
      send_word(random_word(sprbatch_pkg::KIND_BEGIN, 16'h0300));
      for (int i = 0; i < 31; i++)
         send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0300 + 16'(i)));
      // Hit on the last bound slot fills the batch; the next sprite flushes it first.
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h031E));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0400));
      for (int i = 0; i < 30; i++)
         send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0500 + 16'(i)));
      // Every slot is bound, so a new texture flushes with the slot count saturated.
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0600));
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h0600));
   endtask

   task automatic test_lowered_limit();
      send_idle_pct = 0;
      stall_pct = 0;
      write_slot_limit(6'd16);
      send_word(random_word(sprbatch_pkg::KIND_BEGIN, 16'h0700));
      for (int i = 0; i < 5; i++)
         send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0700 + 16'(i)));
      write_slot_limit(6'd3);
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0704));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0700));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0705));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0706));
      send_word(random_word(sprbatch_pkg::KIND_SPRITE, 16'h0707));
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h0707));
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      settle();
      hold_cycles = 400;
      for (int i = 0; i < 16; i++)
         send_word(random_word(sprbatch_pkg::KIND_SPRITE,
                               16'h0800 + 16'($urandom_range(5))));
      send_word(random_word(sprbatch_pkg::KIND_END, 16'h0800));
      settle();
   endtask

   task automatic test_random_phase(input logic [sprbatch_pkg::CFG_W-1:0] limit,
                                    input int idle_pct, input int stall, input int count);
      sprite_word_type w;
      logic [sprbatch_pkg::TEX_W-1:0] base, tex;
      int sent, pick, span;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      write_slot_limit(limit);
      base = sprbatch_pkg::TEX_W'($urandom());
      span = (limit > SLOT_CAP) ? SLOT_CAP + 2 : limit + 2;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         tex = ($urandom_range(7) == 0) ? sprbatch_pkg::TEX_W'($urandom()) :
               base + sprbatch_pkg::TEX_W'($urandom_range(span));
         if (pick < 80) w = random_word(sprbatch_pkg::KIND_SPRITE, tex);
         else if (pick < 88) w = random_word(sprbatch_pkg::KIND_END, tex);
         else if (pick < 94) w = random_word(sprbatch_pkg::KIND_BEGIN, tex);
         else w = random_word(KIND_NONE, tex);
         send_word(w);
         if (w.kind != KIND_NONE) sent++;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_scene_basics();
      test_slot_limit_clamp();
      test_full_batches();
      test_lowered_limit();
      test_output_backpressure();
      test_random_phase(6'd2, 0, 0, 8);
      test_random_phase(6'd32, 57, 0, 8);
      test_random_phase(6'($urandom_range(63)), 0, 57, 8);
      test_random_phase(6'd5, 15, 15, 8);
      settle();
      if (mismatches == 0) begin
         $display("[sprite_batch_slot_and_quad_emit] OK");
      end else begin
         $display("[sprite_batch_slot_and_quad_emit] ERROR");
      end
      $finish;
   end

endmodule
